// File: src/hss_pkg.sv
// ----------------------------------------------------------------------------
// hss_pkg
// Shared types, constants and the quarter-wave sine entry function for the
// harmonic sine synthesiser.
// ----------------------------------------------------------------------------
package hss_pkg;

  localparam int unsigned MAX_HARMONICS = 6;
  localparam int unsigned AMP_W         = 16;
  localparam int unsigned ACC_W         = 32;
  localparam int unsigned SINE_W        = 15;
  localparam int unsigned PROD_W        = 32;
  localparam int unsigned PAIR_W        = 33;
  localparam int unsigned Y_W           = 35;
  localparam int unsigned CFG_IDX_W     = 3;
  localparam int unsigned CFG_DATA_W    = 32;
  localparam int unsigned IN_TDATA_W    = 8;
  localparam int unsigned OUT_TDATA_W   = 72;
  localparam int unsigned FIFO_DEPTH    = 2;

  localparam logic [ACC_W-1:0] PHASE_STEP_RST = 32'd4194304;
  localparam logic [ACC_W-1:0] TIME_STEP_RST  = 32'd128;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PHASE_STEP,
    REG_TIME_STEP,
    REG_AMP_H1,
    REG_AMP_H2,
    REG_AMP_H3,
    REG_AMP_H4,
    REG_AMP_H5,
    REG_AMP_H6
  } cfg_reg_e;

  // one sample request as it leaves the front end
  typedef struct packed {
    logic [ACC_W-1:0] phase;
    logic [ACC_W-1:0] tstamp;
  } smp_t;

  // queue handshake between front and back
  typedef struct packed {
    logic valid;
    smp_t data;
  } smp_req_t;

  // quarter-wave entry i of a table with 2^bits steps, unsigned Q0.15
  function automatic logic [SINE_W-1:0] sine_entry(input int unsigned i,
                                                   input int unsigned bits);
    logic [63:0] a;
    logic [63:0] a2;
    logic [63:0] t;
    logic [63:0] s;
    logic [63:0] v;
    a  = (64'(i) * 64'd1686629713 + ((64'd1 << bits) >> 1)) >> bits;
    a2 = (a * a) >> 30;
    t  = a;
    s  = a;
    t  = ((t * a2) >> 30) / 64'd6;
    s  = s - t;
    t  = ((t * a2) >> 30) / 64'd20;
    s  = s + t;
    t  = ((t * a2) >> 30) / 64'd42;
    s  = s - t;
    t  = ((t * a2) >> 30) / 64'd72;
    s  = s + t;
    t  = ((t * a2) >> 30) / 64'd110;
    s  = s - t;
    v  = (s * 64'd32767 + (64'd1 << 29)) >> 30;
    if (v > 64'd32767) begin
      v = 64'd32767;
    end
    return v[SINE_W-1:0];
  endfunction

endpackage

// File: src/hss_front.sv
// ----------------------------------------------------------------------------
// hss_front
// Input side: takes sample requests, applies restart and advances the phase
// and time accumulators, pushing one sample into the queue per transfer.
// ----------------------------------------------------------------------------
module hss_front
  import hss_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  logic             restart_i,
  input  logic [ACC_W-1:0] phase_step_i,
  input  logic [ACC_W-1:0] time_step_i,
  input  logic             q_full_i,
  output smp_req_t         push_o
);

  logic [ACC_W-1:0] phase_acc_q, phase_acc_d;
  logic [ACC_W-1:0] time_acc_q, time_acc_d;
  logic [ACC_W-1:0] phase_cur;
  logic [ACC_W-1:0] time_cur;
  logic             accept;

  assign s_axis_tready_o = !q_full_i;
  assign accept          = s_axis_tvalid_i && !q_full_i;

  always_comb begin
    phase_cur   = restart_i ? '0 : phase_acc_q;
    time_cur    = restart_i ? '0 : time_acc_q;
    phase_acc_d = phase_acc_q;
    time_acc_d  = time_acc_q;
    if (accept) begin
      phase_acc_d = phase_cur + phase_step_i;
      time_acc_d  = time_cur + time_step_i;
    end
  end

  assign push_o.valid       = accept;
  assign push_o.data.phase  = phase_cur;
  assign push_o.data.tstamp = time_cur;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_acc_q <= '0;
      time_acc_q  <= '0;
    end else begin
      phase_acc_q <= phase_acc_d;
      time_acc_q  <= time_acc_d;
    end
  end

endmodule

// File: src/hss_fifo.sv
// ----------------------------------------------------------------------------
// hss_fifo
// Short sample queue between front and back end, so that either side can
// stall without holding up the other while the queue has room.
// ----------------------------------------------------------------------------
module hss_fifo
  import hss_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  smp_req_t push_i,
  input  logic     pop_i,
  output logic     full_o,
  output smp_req_t head_o
);

  localparam int unsigned PtrW = $clog2(FIFO_DEPTH);
  localparam int unsigned CntW = $clog2(FIFO_DEPTH + 1);

  smp_t            mem_q [FIFO_DEPTH];
  logic [PtrW-1:0] wr_q, wr_d;
  logic [PtrW-1:0] rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push;
  logic            do_pop;

  assign full_o       = (cnt_q == CntW'(FIFO_DEPTH));
  assign head_o.valid = (cnt_q != '0);
  assign head_o.data  = mem_q[rd_q];
  assign do_push      = push_i.valid && !full_o;
  assign do_pop       = pop_i && head_o.valid;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PtrW'(FIFO_DEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == PtrW'(FIFO_DEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!do_push && do_pop) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_i.data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

// File: src/hss_lane.sv
// ----------------------------------------------------------------------------
// hss_lane
// One harmonic: harmonic phase and quadrant folding, quarter-wave sine rom
// with registered read, and the amplitude product.
// ----------------------------------------------------------------------------
module hss_lane
  import hss_pkg::*;
#(
  parameter int unsigned Harmonic  = 1,
  parameter int unsigned TableBits = 10
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic [ACC_W-1:0]         phase_i,
  input  logic signed [AMP_W-1:0]  amp_i,
  output logic signed [PROD_W-1:0] prod_o
);

  localparam int unsigned QLen = 1 << TableBits;

  logic [SINE_W-1:0]       rom [QLen+1];
  logic [ACC_W-1:0]        hphase;
  logic [TableBits-1:0]    idx;
  logic [TableBits:0]      addr_q, addr_d;
  logic                    neg1_q;
  logic                    neg2_q;
  logic [SINE_W-1:0]       sine_q;
  logic signed [AMP_W-1:0] sine_s;
  logic signed [PROD_W-1:0] prod_q;

  for (genvar g = 0; g <= QLen; g++) begin : g_rom
    localparam logic [SINE_W-1:0] Entry = sine_entry(g, TableBits);
    assign rom[g] = Entry;
  end

  assign hphase = 32'(phase_i * 32'(Harmonic));
  assign idx    = hphase[ACC_W-3 -: TableBits];
  assign addr_d = hphase[ACC_W-2] ? (TableBits+1)'(QLen) - {1'b0, idx} : {1'b0, idx};

  assign sine_s = neg2_q ? -$signed({1'b0, sine_q}) : $signed({1'b0, sine_q});

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      addr_q <= addr_d;
      neg1_q <= hphase[ACC_W-1];
      sine_q <= rom[addr_q];
      neg2_q <= neg1_q;
      prod_q <= PROD_W'(amp_i) * PROD_W'(sine_s);
    end
  end

  assign prod_o = prod_q;

endmodule

// File: src/hss_back.sv
// ----------------------------------------------------------------------------
// hss_back
// Execution side: harmonic lanes, two-level adder tree and the output
// register. The whole pipeline advances unless the output is stalled.
// ----------------------------------------------------------------------------
module hss_back
  import hss_pkg::*;
#(
  parameter int unsigned NumHarmonics = 6,
  parameter int unsigned TableBits    = 10
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  smp_req_t                head_i,
  output logic                    pop_o,
  input  logic signed [AMP_W-1:0] amp_i [MAX_HARMONICS],
  output logic                    m_axis_tvalid_o,
  input  logic                    m_axis_tready_i,
  output logic [ACC_W-1:0]        x_value_o,
  output logic signed [Y_W-1:0]   y_value_o
);

  localparam int unsigned Stages = 4;

  logic                     en;
  logic [Stages-1:0]        v_q;
  logic                     out_v_q;
  logic [ACC_W-1:0]         t_q [Stages];
  logic signed [PROD_W-1:0] prod [MAX_HARMONICS];
  logic signed [PAIR_W-1:0] pair_q [MAX_HARMONICS/2];
  logic [ACC_W-1:0]         x_q;
  logic signed [Y_W-1:0]    y_q;

  assign en    = !out_v_q || m_axis_tready_i;
  assign pop_o = en && head_i.valid;

  for (genvar k = 0; k < MAX_HARMONICS; k++) begin : g_lane
    if (k < NumHarmonics) begin : g_on
      hss_lane #(
        .Harmonic (k + 1),
        .TableBits(TableBits)
      ) u_lane (
        .clk_i  (clk_i),
        .en_i   (en),
        .phase_i(head_i.data.phase),
        .amp_i  (amp_i[k]),
        .prod_o (prod[k])
      );
    end else begin : g_off
      assign prod[k] = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      t_q[0] <= head_i.data.tstamp;
      for (int s = 1; s < Stages; s++) begin
        t_q[s] <= t_q[s-1];
      end
      for (int p = 0; p < MAX_HARMONICS/2; p++) begin
        pair_q[p] <= PAIR_W'(prod[2*p]) + PAIR_W'(prod[2*p+1]);
      end
      x_q <= t_q[Stages-1];
      y_q <= Y_W'(pair_q[0]) + Y_W'(pair_q[1]) + Y_W'(pair_q[2]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q     <= '0;
      out_v_q <= 1'b0;
    end else if (en) begin
      v_q     <= {v_q[Stages-2:0], head_i.valid};
      out_v_q <= v_q[Stages-1];
    end
  end

  assign m_axis_tvalid_o = out_v_q;
  assign x_value_o       = x_q;
  assign y_value_o       = y_q;

endmodule

// File: src/harmonic_sine_synthesizer.sv
// ----------------------------------------------------------------------------
// harmonic_sine_synthesizer
// Fourier-series waveform generator: each request yields one (x, y) sample.
// ----------------------------------------------------------------------------
// Every transfer on the input stream asks for one sample; bit 0 of tdata
// (restart) zeroes phase and time first. Samples leave in order through the
// two-entry queue, registered lanes and adder tree, one per clock when the
// output is ready; the rate is set by the phase accumulator and the fully
// pipelined harmonic lanes (one quarter-wave rom and one 16x16 multiplier
// per harmonic). x is the time accumulator in Q16.16, y the sum of amplitude
// times sine in Q6.28. The user writes registers through the cfg port only
// while the block is idle; the block does not enforce this. Map: 0 phase step,
// 1 time step, 2 to 7 the amplitudes of harmonics one to six in Q2.13.
module harmonic_sine_synthesizer
  import hss_pkg::*;
#(
  parameter int unsigned NumHarmonics  = 6,
  parameter int unsigned SineTableBits = 10
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata_i,  // [0] restart
  output logic                   m_axis_tvalid_o,
  input  logic                   m_axis_tready_i,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata_o,  // [31:0] x_value, [66:32] y_value
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i
);

  logic [ACC_W-1:0]        phase_step_q;
  logic [ACC_W-1:0]        time_step_q;
  logic signed [AMP_W-1:0] amp_q [MAX_HARMONICS];
  smp_req_t                push;
  smp_req_t                head;
  logic                    q_full;
  logic                    pop;
  logic [ACC_W-1:0]        x_value;
  logic signed [Y_W-1:0]   y_value;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_step_q <= PHASE_STEP_RST;
      time_step_q  <= TIME_STEP_RST;
      for (int k = 0; k < MAX_HARMONICS; k++) begin
        amp_q[k] <= '0;
      end
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i)) inside
        REG_PHASE_STEP: phase_step_q <= cfg_data_i[ACC_W-1:0];
        REG_TIME_STEP:  time_step_q  <= cfg_data_i[ACC_W-1:0];
        REG_AMP_H1, REG_AMP_H2, REG_AMP_H3, REG_AMP_H4, REG_AMP_H5, REG_AMP_H6: begin
          amp_q[3'(cfg_idx_i - 3'(REG_AMP_H1))] <= cfg_data_i[AMP_W-1:0];
        end
        default: ;
      endcase
    end
  end

  hss_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .restart_i      (s_axis_tdata_i[0]),
    .phase_step_i   (phase_step_q),
    .time_step_i    (time_step_q),
    .q_full_i       (q_full),
    .push_o         (push)
  );

  hss_fifo u_fifo (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .push_i(push),
    .pop_i (pop),
    .full_o(q_full),
    .head_o(head)
  );

  hss_back #(
    .NumHarmonics(NumHarmonics),
    .TableBits   (SineTableBits)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .head_i         (head),
    .pop_o          (pop),
    .amp_i          (amp_q),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .x_value_o      (x_value),
    .y_value_o      (y_value)
  );

  assign m_axis_tdata_o = {(OUT_TDATA_W - ACC_W - Y_W)'(0), y_value, x_value};

endmodule

// File: src/hss_checker.sv
// ----------------------------------------------------------------------------
// hss_checker
// Port-level checks for the harmonic sine synthesiser, bound to the top level.
// ----------------------------------------------------------------------------
module hss_checker
  import hss_pkg::*;
(
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   s_axis_tvalid_i,
  input logic                   s_axis_tready_o,
  input logic                   m_axis_tvalid_o,
  input logic                   m_axis_tready_i,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata_o
);

  logic idle_drain;

  assign idle_drain = !s_axis_tvalid_i && m_axis_tready_i;

  // stalled output transfer keeps its data
  a_out_data_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> $stable(m_axis_tdata_o))
    else $error("output data changed while stalled");

  // stalled output transfer stays offered
  a_out_valid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o)
    else $error("output valid dropped while stalled");

  // the queue only fills up behind a stalled output
  a_full_only_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> $past(m_axis_tvalid_o && !m_axis_tready_i))
    else $error("input stalled without output back-pressure");

  // with no new requests and a free output the pipeline drains
  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idle_drain ##1 idle_drain ##1 idle_drain ##1 idle_drain ##1
    idle_drain ##1 idle_drain ##1 idle_drain ##1 idle_drain |=> !m_axis_tvalid_o)
    else $error("pipeline did not drain");

endmodule

bind harmonic_sine_synthesizer hss_checker u_hss_checker (.*);

// File: sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the harmonic sine synthesiser: every sample request
// is predicted from a local copy of the accumulators, step registers and
// amplitudes, using a locally built quarter-wave sine table. Each output
// transfer is compared with the oldest prediction. Directed samples cover
// the quadrant boundaries, the register extremes and the restart bit. Random
// samples run under several register settings with random gaps on both
// streams and one long output hold-off.
// ----------------------------------------------------------------------------
module tb_top;
  import hss_pkg::*;

  localparam int unsigned N_HARM        = 6;
  localparam int unsigned TAB_BITS      = 10;
  localparam int unsigned QTR           = 1 << TAB_BITS;
  localparam int unsigned SETTLE_CYCLES = 24;
  localparam int unsigned HOLD_CYCLES   = 300;
  localparam int unsigned SEG_ITEMS     = 500;
  localparam int unsigned CFG_EVERY     = 100;

  typedef struct packed {
    logic [ACC_W-1:0] x;
    logic [Y_W-1:0]   y;
  } sample_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   s_axis_tvalid_i = 1'b0;
  logic                   s_axis_tready_o;
  logic [IN_TDATA_W-1:0]  s_axis_tdata_i = '0;   // [0] restart
  logic                   m_axis_tvalid_o;
  logic                   m_axis_tready_i = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata_o;        // [31:0] x_value, [66:32] y_value
  logic                   cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0]  cfg_data_i = '0;

  int unsigned tx_idle_pct = 6;
  int unsigned rx_idle_pct = 73;
  logic        rx_hold = 1'b0;
  int unsigned err_cnt = 0;
  event        hold_go;

  int                sine_tab [0:QTR];
  logic [ACC_W-1:0]  cfg_phase_step;
  logic [ACC_W-1:0]  cfg_time_step;
  logic signed [AMP_W-1:0] cfg_amp [N_HARM];
  logic [ACC_W-1:0]  synth_phase;
  logic [ACC_W-1:0]  synth_time;
  sample_t           pending_samples [$];

  harmonic_sine_synthesizer #(
    .NumHarmonics (N_HARM),
    .SineTableBits(TAB_BITS)
  ) dut (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid_i,
    .s_axis_tready_o,
    .s_axis_tdata_i,
    .m_axis_tvalid_o,
    .m_axis_tready_i,
    .m_axis_tdata_o,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_data_i
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // quarter-wave table from a truncated Taylor series in Q2.30
  function automatic void build_sine_tab();
    longint unsigned a, a2, term, acc, v;
    for (int i = 0; i <= QTR; i++) begin
      a    = (longint'(i) * 64'd1686629713 + QTR / 2) >> TAB_BITS;
      a2   = (a * a) >> 30;
      term = a;
      acc  = a;
      for (int n = 1; n <= 9; n += 2) begin
        term = ((term * a2) >> 30) / longint'((n + 1) * (n + 2));
        if (((n + 1) >> 1) & 1) begin
          acc = acc - term;
        end else begin
          acc = acc + term;
        end
      end
      v = (acc * 64'd32767 + (64'd1 << 29)) >> 30;
      sine_tab[i] = (v > 64'd32767) ? 32767 : int'(v);
    end
  endfunction

  function automatic int sine_at(logic [ACC_W-1:0] p);
    logic [1:0] quad;
    int         idx;
    int         v;
    quad = p[31:30];
    idx  = int'(p[29 -: TAB_BITS]);
    v    = quad[0] ? sine_tab[QTR - idx] : sine_tab[idx];
    return quad[1] ? -v : v;
  endfunction

  function automatic void reset_synth_model();
    cfg_phase_step = PHASE_STEP_RST;
    cfg_time_step  = TIME_STEP_RST;
    foreach (cfg_amp[k]) cfg_amp[k] = '0;
    synth_phase = '0;
    synth_time  = '0;
  endfunction

  function automatic void predict_sample(logic restart);
    logic [ACC_W-1:0] hp;
    longint           y;
    sample_t          s;
    if (restart) begin
      synth_phase = '0;
      synth_time  = '0;
    end
    y = 0;
    for (int k = 0; k < N_HARM; k++) begin
      hp = synth_phase * (k + 1);
      y  = y + longint'(cfg_amp[k]) * longint'(sine_at(hp));
    end
    s.x = synth_time;
    s.y = y[Y_W-1:0];
    pending_samples.push_back(s);
    synth_phase = synth_phase + cfg_phase_step;
    synth_time  = synth_time + cfg_time_step;
  endfunction

  task automatic send_sample(input logic restart, input logic [IN_TDATA_W-2:0] pad = '0);
    @(negedge clk_i);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {pad, restart};
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    predict_sample(restart);
  endtask

  task automatic drain_samples();
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b0;
    while (pending_samples.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_PHASE_STEP: cfg_phase_step = val;
      REG_TIME_STEP:  cfg_time_step  = val;
      default:        cfg_amp[idx - REG_AMP_H1] = val[AMP_W-1:0];
    endcase
  endtask

  task automatic set_all_regs(input logic [ACC_W-1:0] ps, input logic [ACC_W-1:0] ts,
                              input logic [AMP_W-1:0] amps [N_HARM]);
    drain_samples();
    write_reg(REG_PHASE_STEP, ps);
    write_reg(REG_TIME_STEP, ts);
    for (int k = 0; k < N_HARM; k++) begin
      write_reg(cfg_reg_e'(REG_AMP_H1 + k), {16'h0000, amps[k]});
    end
  endtask

  task automatic test_reset_defaults();
    send_sample(1'b0);
    send_sample(1'b0);
    send_sample(1'b1);
    send_sample(1'b0);
  endtask

  task automatic test_extremes();
    logic [AMP_W-1:0] amps [N_HARM];
    // quarter-turn steps hit every quadrant edge, x wraps
    foreach (amps[k]) amps[k] = 16'h7FFF;
    set_all_regs(32'h4000_0000, 32'hFFFF_FFFF, amps);
    send_sample(1'b1);
    repeat (4) send_sample(1'b0);
    foreach (amps[k]) amps[k] = 16'h8000;
    set_all_regs(32'hFFFF_FFFF, 32'h0000_0000, amps);
    send_sample(1'b0);
    repeat (4) send_sample(1'b0);
    foreach (amps[k]) amps[k] = k[0] ? 16'h8000 : 16'h7FFF;
    set_all_regs(32'h0000_0000, 32'h0000_0001, amps);
    send_sample(1'b0);
    send_sample(1'b1);
    foreach (amps[k]) amps[k] = 16'h2000 >> k;
    set_all_regs(32'h0010_0000, 32'h0001_0000, amps);
    send_sample(1'b1);
    send_sample(1'b0);
    // upper tdata bits carry no meaning
    send_sample(1'b0, '1);
    send_sample(1'b1, '1);
    send_sample(1'b0, 7'h2A);
    send_sample(1'b1, 7'h55);
  endtask

  task automatic random_regs();
    logic [AMP_W-1:0] amps [N_HARM];
    logic [ACC_W-1:0] ps;
    foreach (amps[k]) begin
      case ($urandom_range(3))
        0:       amps[k] = 16'h7FFF;
        1:       amps[k] = 16'h8000;
        default: amps[k] = AMP_W'($urandom);
      endcase
    end
    ps = $urandom_range(1) ? $urandom : $urandom_range(32'h0100_0000);
    set_all_regs(ps, $urandom, amps);
  endtask

  task automatic run_random_segment(input int unsigned tx_pct, input int unsigned rx_pct);
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    for (int unsigned n = 0; n < SEG_ITEMS; n++) begin
      if (n % CFG_EVERY == 0) random_regs();
      send_sample($urandom_range(99) < 3);
    end
  endtask

  task automatic test_random();
    run_random_segment(6, 73);
    run_random_segment(73, 6);
    run_random_segment(0, 0);
  endtask

  task automatic test_backpressure();
    random_regs();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    -> hold_go;
    repeat (60) send_sample($urandom_range(99) < 3);
    drain_samples();
  endtask

  always @(negedge clk_i) begin
    m_axis_tready_i <= !rx_hold && ($urandom_range(99) >= rx_idle_pct);
  end

  // long output hold-off so the input queue fills and stalls
  always begin
    @(hold_go);
    @(posedge clk_i);
    rx_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    rx_hold <= 1'b0;
  end

  always @(posedge clk_i) begin
    sample_t          want;
    logic [ACC_W-1:0] got_x;
    logic [Y_W-1:0]   got_y;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got_x = m_axis_tdata_o[ACC_W-1:0];
      got_y = m_axis_tdata_o[ACC_W +: Y_W];
      if (pending_samples.size() == 0) begin
        $error("unexpected output transfer: x_value %0h y_value %0h", got_x, got_y);
        err_cnt++;
      end else begin
        want = pending_samples.pop_front();
        if (got_x !== want.x) begin
          $error("x_value: expected %0h, got %0h", want.x, got_x);
          err_cnt++;
        end
        if (got_y !== want.y) begin
          $error("y_value: expected %0h, got %0h", want.y, got_y);
          err_cnt++;
        end
      end
    end
  end

  initial begin
    build_sine_tab();
    reset_synth_model();
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_reset_defaults();
    test_extremes();
    test_random();
    test_backpressure();
    drain_samples();
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
